### rtl/ptcp_pkg.sv
// Shared widths and types for the closest-point-on-triangle pipeline.
// Used by ptcp_rdiv and point_triangle_closest_point; depends on nothing.
`default_nettype none

package ptcp_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int NRM_W      = 2 * DIFF_W;
    localparam int DD_W       = 2 * NRM_W;
    localparam int SIN_W      = 2 * NRM_W + 1;
    localparam int S_W        = DIFF_W + NRM_W + 1;
    localparam int SPLIT      = S_W / 2;
    localparam int PLO_W      = SPLIT + 1 + NRM_W;
    localparam int PHI_W      = (S_W - SPLIT) + NRM_W;
    localparam int PROD_W     = S_W + NRM_W;
    localparam int T_W        = 2 * DIFF_W + 1;
    localparam int LEN_W      = 2 * DIFF_W;
    localparam int TEK_W      = T_W + DIFF_W;
    localparam int DIV_NUM_W  = PROD_W;
    localparam int DIV_DEN_W  = DD_W + 1;
    localparam int DIV_Q_W    = DIFF_W + 2;
    localparam int QUO_W      = DIV_Q_W + 1;
    localparam int SQ_W       = 2 * DIFF_W - 2;
    localparam int DIST_W     = 2 * COORD_BITS + 2;
    localparam int LANES      = 12;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [DIV_NUM_W-1:0]         num_t;
    typedef logic [DIV_DEN_W-1:0]         den_t;
    typedef logic signed [QUO_W-1:0]      quo_t;

endpackage

`default_nettype wire

### rtl/ptcp_rdiv.sv
// Pipelined restoring divider giving floor(num / den) with the sign applied.
// One quotient bit per register stage; depends on ptcp_pkg.
`default_nettype none

module ptcp_rdiv (
    input  logic           clk,
    input  logic           adv,
    input  ptcp_pkg::num_t num,
    input  ptcp_pkg::den_t den,
    input  logic           neg,
    output ptcp_pkg::quo_t quo
);
    import ptcp_pkg::*;

    localparam int CMP_W = DIV_DEN_W + DIV_Q_W - 1;

    num_t               rem_reg [DIV_Q_W-1];
    den_t               den_reg [DIV_Q_W-1];
    logic [DIV_Q_W-1:0] q_reg   [DIV_Q_W];
    logic               neg_reg [DIV_Q_W];

    for (genvar j = 0; j < DIV_Q_W; j++)
    begin : g_bit
        localparam int BIT = DIV_Q_W - 1 - j;
        logic [CMP_W-1:0]   rem_in;
        logic [CMP_W-1:0]   sub;
        den_t               den_in;
        logic [DIV_Q_W-1:0] q_in;
        logic               neg_in;
        logic               ge;

        if (j == 0)
        begin : g_first
            assign rem_in = CMP_W'(num);
            assign den_in = den;
            assign q_in   = '0;
            assign neg_in = neg;
        end
        else
        begin : g_later
            assign rem_in = CMP_W'(rem_reg[j-1]);
            assign den_in = den_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign neg_in = neg_reg[j-1];
        end

        assign sub = CMP_W'(den_in) << BIT;
        assign ge  = rem_in >= sub;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[j]   <= q_in | (ge ? (DIV_Q_W'(1) << BIT) : '0);
                neg_reg[j] <= neg_in;
            end
        end

        if (j < DIV_Q_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[j] <= DIV_NUM_W'(ge ? rem_in - sub : rem_in);
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo = neg_reg[DIV_Q_W-1] ? -quo_t'({1'b0, q_reg[DIV_Q_W-1]})
                                    : quo_t'({1'b0, q_reg[DIV_Q_W-1]});

endmodule

`default_nettype wire

### rtl/point_triangle_closest_point.sv
// Closest point on a triangle to a query point, signed fixed point, fully pipelined.
// Depends on ptcp_pkg and ptcp_rdiv.
//
//   Channel   Handshake             Contents
//   request   req_valid/req_ready   corners a, b, c and query point
//   response  rsp_valid/rsp_ready   nearest point, squared distance, inside flag
//
// A new transfer is taken every cycle while no response waits; the restoring
// dividers produce one quotient bit per stage.
// The whole pipeline advances together and holds while a response waits.
// Reset clears only the stage valid bits.
`default_nettype none

module point_triangle_closest_point (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  ptcp_pkg::coord_t              corner_a_x,
    input  ptcp_pkg::coord_t              corner_a_y,
    input  ptcp_pkg::coord_t              corner_a_z,
    input  ptcp_pkg::coord_t              corner_b_x,
    input  ptcp_pkg::coord_t              corner_b_y,
    input  ptcp_pkg::coord_t              corner_b_z,
    input  ptcp_pkg::coord_t              corner_c_x,
    input  ptcp_pkg::coord_t              corner_c_y,
    input  ptcp_pkg::coord_t              corner_c_z,
    input  ptcp_pkg::coord_t              query_x,
    input  ptcp_pkg::coord_t              query_y,
    input  ptcp_pkg::coord_t              query_z,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output ptcp_pkg::coord_t              nearest_x,
    output ptcp_pkg::coord_t              nearest_y,
    output ptcp_pkg::coord_t              nearest_z,
    output logic [ptcp_pkg::DIST_W-1:0]   squared_distance,
    output logic                          inside_face
);
    import ptcp_pkg::*;

    localparam int NSTAGE  = DIV_Q_W + 10;
    localparam int DIV_OUT = DIV_Q_W + 5;
    localparam int NXT [3] = '{1, 2, 0};

    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [NRM_W-1:0]   nrm_t;
    typedef logic [DD_W-1:0]           dd_t;
    typedef logic signed [SIN_W-1:0]   sin_t;
    typedef logic signed [S_W-1:0]     s_t;
    typedef logic signed [PLO_W-1:0]   plo_t;
    typedef logic signed [PHI_W-1:0]   phi_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [T_W-1:0]     dot_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic signed [TEK_W-1:0]   tek_t;
    typedef logic signed [QUO_W:0]     psum_t;
    typedef logic [SQ_W-1:0]           sq_t;
    typedef logic [DIST_W-1:0]         dist_t;

    typedef struct {
        coord_t c [3][3];
        coord_t p [3];
        diff_t  e [3][3];
        dot_t   t [3];
        len_t   len [3];
        logic   in_face;
    } side_t;

    logic              adv;
    logic [NSTAGE-1:0] v_reg;
    coord_t            c_in [3][3];
    coord_t            p_in [3];

    coord_t a_c_reg [3][3];
    coord_t a_p_reg [3];
    diff_t  a_e_reg [3][3];
    diff_t  a_w_reg [3][3];

    nrm_t   b_n_reg [3];
    nrm_t   b_x_reg [3][3];
    diff_t  b_w0_reg [3];
    side_t  b_side_reg;

    dd_t    c_dd_reg;
    sin_t   c_sin_reg [3];
    s_t     c_s_reg;
    tek_t   c_tek_reg [3][3];
    nrm_t   c_n_reg [3];
    side_t  c_side_reg;

    dd_t    d_dd_reg;
    plo_t   d_plo_reg [3];
    phi_t   d_phi_reg [3];
    tek_t   d_tek_reg [3][3];
    side_t  d_side_reg;

    dd_t    e_dd_reg;
    prod_t  e_prod_reg [3];
    tek_t   e_tek_reg [3][3];
    side_t  e_side_reg;

    num_t   f_num_next [LANES];
    den_t   f_den_next [LANES];
    logic   f_neg_next [LANES];
    num_t   f_num_reg [LANES];
    den_t   f_den_reg [LANES];
    logic   f_neg_reg [LANES];
    side_t  f_side_reg;

    quo_t   quo [LANES];
    side_t  side_reg [DIV_Q_W];

    psum_t  g_psum [3];
    logic [2:0] g_fit;
    coord_t g_pt_reg [3];
    coord_t g_cand_reg [3][3];
    coord_t g_p_reg [3];
    logic   g_inside_reg;

    coord_t h_pt_reg [3];
    coord_t h_cand_reg [3][3];
    sq_t    h_sqp_reg [3];
    sq_t    h_sqc_reg [3][3];
    logic   h_inside_reg;

    coord_t i_pt_reg [3];
    coord_t i_cand_reg [3][3];
    dist_t  i_dp_reg;
    dist_t  i_dc_reg [3];
    logic   i_inside_reg;

    coord_t nearest_reg [3];
    dist_t  dist_reg;
    logic   inside_reg;

    assign adv       = !v_reg[NSTAGE-1] || rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = v_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTAGE-2:0], req_valid};
        end
    end

    always_comb
    begin
        c_in[0][0] = corner_a_x;
        c_in[0][1] = corner_a_y;
        c_in[0][2] = corner_a_z;
        c_in[1][0] = corner_b_x;
        c_in[1][1] = corner_b_y;
        c_in[1][2] = corner_b_z;
        c_in[2][0] = corner_c_x;
        c_in[2][1] = corner_c_y;
        c_in[2][2] = corner_c_z;
        p_in[0]    = query_x;
        p_in[1]    = query_y;
        p_in[2]    = query_z;
    end

    // Edge vectors and query offsets from each edge start.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_c_reg <= c_in;
            a_p_reg <= p_in;
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    a_e_reg[i][k] <= diff_t'(c_in[NXT[i]][k]) - diff_t'(c_in[i][k]);
                    a_w_reg[i][k] <= diff_t'(p_in[k]) - diff_t'(c_in[i][k]);
                end
            end
        end
    end

    // Plane normal, edge cross products, edge projections and squared lengths.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_n_reg[0] <= nrm_t'(a_e_reg[0][1]) * nrm_t'(a_e_reg[1][2])
                        - nrm_t'(a_e_reg[0][2]) * nrm_t'(a_e_reg[1][1]);
            b_n_reg[1] <= nrm_t'(a_e_reg[0][2]) * nrm_t'(a_e_reg[1][0])
                        - nrm_t'(a_e_reg[0][0]) * nrm_t'(a_e_reg[1][2]);
            b_n_reg[2] <= nrm_t'(a_e_reg[0][0]) * nrm_t'(a_e_reg[1][1])
                        - nrm_t'(a_e_reg[0][1]) * nrm_t'(a_e_reg[1][0]);
            for (int i = 0; i < 3; i++)
            begin
                b_x_reg[i][0] <= nrm_t'(a_e_reg[i][1]) * nrm_t'(a_w_reg[i][2])
                               - nrm_t'(a_e_reg[i][2]) * nrm_t'(a_w_reg[i][1]);
                b_x_reg[i][1] <= nrm_t'(a_e_reg[i][2]) * nrm_t'(a_w_reg[i][0])
                               - nrm_t'(a_e_reg[i][0]) * nrm_t'(a_w_reg[i][2]);
                b_x_reg[i][2] <= nrm_t'(a_e_reg[i][0]) * nrm_t'(a_w_reg[i][1])
                               - nrm_t'(a_e_reg[i][1]) * nrm_t'(a_w_reg[i][0]);
                b_side_reg.t[i] <= dot_t'(a_w_reg[i][0]) * dot_t'(a_e_reg[i][0])
                                 + dot_t'(a_w_reg[i][1]) * dot_t'(a_e_reg[i][1])
                                 + dot_t'(a_w_reg[i][2]) * dot_t'(a_e_reg[i][2]);
                b_side_reg.len[i] <= LEN_W'(dot_t'(a_e_reg[i][0]) * dot_t'(a_e_reg[i][0])
                                          + dot_t'(a_e_reg[i][1]) * dot_t'(a_e_reg[i][1])
                                          + dot_t'(a_e_reg[i][2]) * dot_t'(a_e_reg[i][2]));
            end
            b_w0_reg           <= a_w_reg[0];
            b_side_reg.c       <= a_c_reg;
            b_side_reg.p       <= a_p_reg;
            b_side_reg.e       <= a_e_reg;
            b_side_reg.in_face <= 1'b0;
        end
    end

    // Squared normal length, inside tests, plane offset and edge numerators.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_dd_reg <= DD_W'(sin_t'(b_n_reg[0]) * sin_t'(b_n_reg[0])
                            + sin_t'(b_n_reg[1]) * sin_t'(b_n_reg[1])
                            + sin_t'(b_n_reg[2]) * sin_t'(b_n_reg[2]));
            for (int i = 0; i < 3; i++)
            begin
                c_sin_reg[i] <= sin_t'(b_n_reg[0]) * sin_t'(b_x_reg[i][0])
                              + sin_t'(b_n_reg[1]) * sin_t'(b_x_reg[i][1])
                              + sin_t'(b_n_reg[2]) * sin_t'(b_x_reg[i][2]);
                for (int k = 0; k < 3; k++)
                begin
                    c_tek_reg[i][k] <= tek_t'(b_side_reg.t[i]) * tek_t'(b_side_reg.e[i][k]);
                end
            end
            c_s_reg <= -(s_t'(b_w0_reg[0]) * s_t'(b_n_reg[0])
                       + s_t'(b_w0_reg[1]) * s_t'(b_n_reg[1])
                       + s_t'(b_w0_reg[2]) * s_t'(b_n_reg[2]));
            c_n_reg    <= b_n_reg;
            c_side_reg <= b_side_reg;
        end
    end

    // Inside decision and the two halves of the projection product.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_plo_reg[k] <= plo_t'($signed({1'b0, c_s_reg[SPLIT-1:0]}))
                              * plo_t'(c_n_reg[k]);
                d_phi_reg[k] <= phi_t'($signed(c_s_reg[S_W-1:SPLIT])) * phi_t'(c_n_reg[k]);
            end
            d_dd_reg           <= c_dd_reg;
            d_tek_reg          <= c_tek_reg;
            d_side_reg.c       <= c_side_reg.c;
            d_side_reg.p       <= c_side_reg.p;
            d_side_reg.e       <= c_side_reg.e;
            d_side_reg.t       <= c_side_reg.t;
            d_side_reg.len     <= c_side_reg.len;
            d_side_reg.in_face <= (c_dd_reg != '0) && (c_sin_reg[0] > 0)
                               && (c_sin_reg[1] > 0) && (c_sin_reg[2] > 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_prod_reg[k] <= (prod_t'(d_phi_reg[k]) <<< SPLIT) + prod_t'(d_plo_reg[k]);
            end
            e_dd_reg   <= d_dd_reg;
            e_tek_reg  <= d_tek_reg;
            e_side_reg <= d_side_reg;
        end
    end

    // Divider operands: lanes 0 to 2 are the projection, then three per edge.
    always_comb
    begin
        prod_t mp;
        tek_t  mt;
        for (int k = 0; k < 3; k++)
        begin
            mp            = (e_prod_reg[k] < 0) ? -e_prod_reg[k] : e_prod_reg[k];
            f_num_next[k] = (num_t'(unsigned'(mp)) << 1) + num_t'(e_dd_reg);
            f_den_next[k] = den_t'({e_dd_reg, 1'b0});
            f_neg_next[k] = e_prod_reg[k] < 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mt = (e_tek_reg[i][k] < 0) ? -e_tek_reg[i][k] : e_tek_reg[i][k];
                f_num_next[3 + 3 * i + k] = (num_t'(unsigned'(mt)) << 1)
                                          + num_t'(e_side_reg.len[i]);
                f_den_next[3 + 3 * i + k] = den_t'({e_side_reg.len[i], 1'b0});
                f_neg_next[3 + 3 * i + k] = e_tek_reg[i][k] < 0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_num_reg  <= f_num_next;
            f_den_reg  <= f_den_next;
            f_neg_reg  <= f_neg_next;
            f_side_reg <= e_side_reg;
        end
    end

    for (genvar j = 0; j < LANES; j++)
    begin : g_div
        ptcp_rdiv u_rdiv (
            .clk (clk),
            .adv (adv),
            .num (f_num_reg[j]),
            .den (f_den_reg[j]),
            .neg (f_neg_reg[j]),
            .quo (quo[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= f_side_reg;
            for (int j = 1; j < DIV_Q_W; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            g_psum[k] = psum_t'(side_reg[DIV_Q_W-1].p[k]) + psum_t'(quo[k]);
            g_fit[k]  = (&g_psum[k][QUO_W:COORD_BITS-1]) || !(|g_psum[k][QUO_W:COORD_BITS-1]);
        end
    end

    // Projection with saturation, and the clamped point on each edge.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                g_pt_reg[k] <= g_fit[k] ? coord_t'(g_psum[k])
                             : coord_t'({g_psum[k][QUO_W], {(COORD_BITS-1){!g_psum[k][QUO_W]}}});
            end
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (side_reg[DIV_Q_W-1].len[i] == '0 || side_reg[DIV_Q_W-1].t[i] < 0)
                    begin
                        g_cand_reg[i][k] <= side_reg[DIV_Q_W-1].c[i][k];
                    end
                    else if (side_reg[DIV_Q_W-1].t[i] > $signed({1'b0, side_reg[DIV_Q_W-1].len[i]}))
                    begin
                        g_cand_reg[i][k] <= side_reg[DIV_Q_W-1].c[NXT[i]][k];
                    end
                    else
                    begin
                        g_cand_reg[i][k] <= coord_t'(side_reg[DIV_Q_W-1].c[i][k]
                                                   + coord_t'(quo[3 + 3 * i + k]));
                    end
                end
            end
            g_p_reg      <= side_reg[DIV_Q_W-1].p;
            g_inside_reg <= side_reg[DIV_Q_W-1].in_face;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                h_sqp_reg[k] <= SQ_W'((nrm_t'(g_pt_reg[k]) - nrm_t'(g_p_reg[k]))
                                    * (nrm_t'(g_pt_reg[k]) - nrm_t'(g_p_reg[k])));
                for (int i = 0; i < 3; i++)
                begin
                    h_sqc_reg[i][k] <= SQ_W'((nrm_t'(g_cand_reg[i][k]) - nrm_t'(g_p_reg[k]))
                                           * (nrm_t'(g_cand_reg[i][k]) - nrm_t'(g_p_reg[k])));
                end
            end
            h_pt_reg     <= g_pt_reg;
            h_cand_reg   <= g_cand_reg;
            h_inside_reg <= g_inside_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_dp_reg <= dist_t'(h_sqp_reg[0]) + dist_t'(h_sqp_reg[1]) + dist_t'(h_sqp_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                i_dc_reg[i] <= dist_t'(h_sqc_reg[i][0]) + dist_t'(h_sqc_reg[i][1])
                             + dist_t'(h_sqc_reg[i][2]);
            end
            i_pt_reg     <= h_pt_reg;
            i_cand_reg   <= h_cand_reg;
            i_inside_reg <= h_inside_reg;
        end
    end

    // Inside the face the projection wins; else the nearest edge, on a tie the lower edge index.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inside_reg <= i_inside_reg;
            if (i_inside_reg)
            begin
                nearest_reg <= i_pt_reg;
                dist_reg    <= i_dp_reg;
            end
            else if (i_dc_reg[1] < i_dc_reg[0] && i_dc_reg[2] >= i_dc_reg[1])
            begin
                nearest_reg <= i_cand_reg[1];
                dist_reg    <= i_dc_reg[1];
            end
            else if (i_dc_reg[2] < i_dc_reg[0] && i_dc_reg[2] < i_dc_reg[1])
            begin
                nearest_reg <= i_cand_reg[2];
                dist_reg    <= i_dc_reg[2];
            end
            else
            begin
                nearest_reg <= i_cand_reg[0];
                dist_reg    <= i_dc_reg[0];
            end
        end
    end

    assign nearest_x        = nearest_reg[0];
    assign nearest_y        = nearest_reg[1];
    assign nearest_z        = nearest_reg[2];
    assign squared_distance = dist_reg;
    assign inside_face      = inside_reg;

`ifndef SYNTH
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> v_reg[0])
        else $error("Accepted transfer did not enter the first stage.");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("Pipeline valid bits moved during a stall.");

    a_inside_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[DIV_OUT] && side_reg[DIV_Q_W-1].in_face |-> (&g_fit))
        else $error("Projection of an inside point left the coordinate range.");
`endif

endmodule

`default_nettype wire
